### hw/rtl/lne_pkg.sv
// Shared types and constants for the layer normalization engine.
// Used by lne_front, lne_back and layer_norm_engine; depends on nothing.
package lne_pkg;

  localparam int MAX_LENGTH = 1024;
  localparam int IDX_W      = $clog2(MAX_LENGTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int DATA_W     = 24;
  localparam int LEN_W      = 11;
  localparam int EPS_W      = 32;
  localparam int CFG_W      = 32;
  localparam int SUM_W      = DATA_W + IDX_W;
  localparam int SQ_W       = 2 * DATA_W - 1 + IDX_W;
  localparam int DIV_W      = 65;
  localparam int DEN_W      = 60;
  localparam int RSTD_W     = 32;
  localparam int NORM_W     = 41;

  localparam logic [LEN_W-1:0] LENGTH_RESET  = LEN_W'(768);
  localparam logic [EPS_W-1:0] EPSILON_RESET = EPS_W'(42950);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EMIT = 1'b1;

  localparam logic CFG_LENGTH  = 1'b0;
  localparam logic CFG_EPSILON = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EARLY = 2'd1;
  localparam logic [1:0] STATUS_DROP  = 2'd2;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] gamma;
    logic signed [DATA_W-1:0] beta;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD_MUL,
    S_LOAD_ACC,
    S_MEAN_DIV,
    S_MEAN_SET,
    S_SQ_DIV,
    S_MSQ,
    S_VAR,
    S_LIM_DIV,
    S_LIM_SET,
    S_RSQ_MUL,
    S_RSQ_CMP,
    S_EMIT_RD,
    S_EMIT_MUL,
    S_EMIT_NORM,
    S_EMIT_SPLIT,
    S_EMIT_SUM
  } state_t;

endpackage

### hw/rtl/lne_front.sv
// Request front end: accepts requests and holds them in a two-entry queue.
// Depends on lne_pkg; feeds lne_back.
module lne_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic                             mode,
  input  logic signed [lne_pkg::DATA_W-1:0] x_value,
  input  logic signed [lne_pkg::DATA_W-1:0] scale_value,
  input  logic signed [lne_pkg::DATA_W-1:0] shift_value,
  output lne_pkg::q_head_t                 head,
  input  logic                             pop
);
  import lne_pkg::*;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;

  assign item_stall = (cnt == 2'd2);
  assign push       = item_valid && !item_stall;
  assign head.valid = (cnt != 2'd0);
  assign head.item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{mode: mode, x: x_value, gamma: scale_value, beta: shift_value};
    end
  end

endmodule

### hw/rtl/lne_back.sv
// Execution back end: element store, sums, statistics sequencer and output math.
// Depends on lne_pkg; takes requests from lne_front.
module lne_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [lne_pkg::CFG_W-1:0]         cfg_data,
  input  lne_pkg::q_head_t                  head,
  output logic                              pop,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [lne_pkg::DATA_W-1:0] normalized_value,
  output logic [lne_pkg::IDX_W-1:0]         element_index,
  output logic                              last_of_vector,
  output logic [1:0]                        status
);
  import lne_pkg::*;

  localparam logic signed [65:0] NORM_LIMIT = 66'sd549755813887;
  localparam logic signed [65:0] OUT_MAX    = 66'sd8388607;
  localparam logic signed [65:0] OUT_MIN    = -66'sd8388608;

  function automatic logic signed [65:0] rnd16(input logic signed [65:0] v);
    logic [65:0] mag;
    logic [65:0] r;
    mag = v[65] ? 66'(-v) : 66'(v);
    r   = (mag + 66'd32768) >> 16;
    return v[65] ? -$signed(r) : $signed(r);
  endfunction

  state_t state, state_next;

  logic [LEN_W-1:0]         vlen;
  logic [EPS_W-1:0]         eps;
  logic                     phase;
  logic [CNT_W-1:0]         loaded_count;
  logic [IDX_W-1:0]         emit_index;
  logic signed [SUM_W-1:0]  running_sum;
  logic [SQ_W-1:0]          running_square_sum;

  item_t                    cur;
  logic signed [DATA_W-1:0] mem [MAX_LENGTH];
  logic signed [DATA_W-1:0] rd_data;
  logic [2*DATA_W-1:0]      sqp;

  logic [DIV_W-1:0]         div_quo;
  logic [DEN_W-1:0]         div_den;
  logic [DEN_W-1:0]         div_rem;
  logic [6:0]               div_cnt;
  logic [DEN_W:0]           div_shift;
  logic                     div_ge;

  logic [DATA_W-1:0]        m_mag;
  logic signed [DATA_W-1:0] vector_mean;
  logic [SQ_W-1:0]          qn;
  logic [2*DATA_W-1:0]      msq;
  logic [63:0]              lim;
  logic [RSTD_W-1:0]        rsq_res;
  logic [4:0]               rsq_bit;
  logic [RSTD_W-1:0]        rsq_cand;
  logic [63:0]              sqr;
  logic [RSTD_W-1:0]        reciprocal_std;
  logic [DEN_W-1:0]         v_comb;
  logic                     v_small;

  logic signed [57:0]       prod;
  logic signed [NORM_W-1:0] norm;
  logic signed [44:0]       ph;
  logic signed [44:0]       pl;

  logic [CNT_W-1:0]         len_eff;
  logic                     full;
  logic                     take;
  logic                     is_load;
  logic                     drop_now;
  logic                     early_now;
  logic                     last;
  logic [SUM_W-1:0]         sum_mag;
  logic signed [DATA_W:0]   d;
  logic signed [65:0]       n_r;
  logic signed [65:0]       ysum;
  logic signed [65:0]       y_r;

  always_comb begin
    if (vlen == '0) len_eff = CNT_W'(1);
    else if (int'(vlen) > MAX_LENGTH) len_eff = CNT_W'(MAX_LENGTH);
    else len_eff = CNT_W'(vlen);
  end

  assign full      = (loaded_count >= len_eff);
  assign take      = (state == S_IDLE) && head.valid && !result_valid;
  assign is_load   = (head.item.mode == MODE_LOAD);
  assign drop_now  = take && is_load && (phase || full);
  assign early_now = take && !is_load && !phase && !full;
  assign last      = (CNT_W'(emit_index) + CNT_W'(1) >= loaded_count);
  assign sum_mag   = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);

  assign div_shift = {div_rem, div_quo[DIV_W-1]};
  assign div_ge    = (div_shift >= {1'b0, div_den});

  assign v_comb   = ((qn > SQ_W'(msq)) ? DEN_W'(qn - SQ_W'(msq)) : '0) + DEN_W'(eps);
  assign v_small  = (v_comb <= DEN_W'(1));
  assign rsq_cand = rsq_res | (RSTD_W'(1) << rsq_bit);

  assign d    = (DATA_W+1)'(rd_data) - (DATA_W+1)'(vector_mean);
  assign n_r  = rnd16(66'(prod));
  assign ysum = (66'(ph) <<< 20) + 66'(pl) + (66'(cur.beta) <<< 16);
  assign y_r  = rnd16(ysum);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          pop = 1'b1;
          if (is_load) begin
            if (!phase && !full) state_next = S_LOAD_MUL;
          end else if (phase) begin
            state_next = S_EMIT_RD;
          end else if (full) begin
            state_next = S_MEAN_DIV;
          end
        end
      end
      S_LOAD_MUL:   state_next = S_LOAD_ACC;
      S_LOAD_ACC:   state_next = S_IDLE;
      S_MEAN_DIV:   if (div_cnt == '0) state_next = S_MEAN_SET;
      S_MEAN_SET:   state_next = S_SQ_DIV;
      S_SQ_DIV:     if (div_cnt == '0) state_next = S_MSQ;
      S_MSQ:        state_next = S_VAR;
      S_VAR:        state_next = v_small ? S_EMIT_RD : S_LIM_DIV;
      S_LIM_DIV:    if (div_cnt == '0) state_next = S_LIM_SET;
      S_LIM_SET:    state_next = S_RSQ_MUL;
      S_RSQ_MUL:    state_next = S_RSQ_CMP;
      S_RSQ_CMP:    state_next = (rsq_bit == '0) ? S_EMIT_RD : S_RSQ_MUL;
      S_EMIT_RD:    state_next = S_EMIT_MUL;
      S_EMIT_MUL:   state_next = S_EMIT_NORM;
      S_EMIT_NORM:  state_next = S_EMIT_SPLIT;
      S_EMIT_SPLIT: state_next = S_EMIT_SUM;
      S_EMIT_SUM:   state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      vlen               <= LENGTH_RESET;
      eps                <= EPSILON_RESET;
      phase              <= 1'b0;
      loaded_count       <= '0;
      emit_index         <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      result_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LENGTH:  vlen <= cfg_data[LEN_W-1:0];
          CFG_EPSILON: eps  <= cfg_data[EPS_W-1:0];
          default:     ;
        endcase
      end
      if (result_valid && !result_stall) result_valid <= 1'b0;
      if (drop_now || early_now) result_valid <= 1'b1;
      if (state == S_LOAD_ACC) begin
        running_sum        <= running_sum + SUM_W'(cur.x);
        running_square_sum <= running_square_sum + SQ_W'(sqp);
        loaded_count       <= loaded_count + CNT_W'(1);
      end
      if ((state == S_VAR && v_small) || (state == S_RSQ_CMP && rsq_bit == '0)) begin
        phase <= 1'b1;
      end
      if (state == S_EMIT_SUM) begin
        result_valid <= 1'b1;
        if (last) begin
          running_sum        <= '0;
          running_square_sum <= '0;
          loaded_count       <= '0;
          emit_index         <= '0;
          phase              <= 1'b0;
        end else begin
          emit_index <= emit_index + IDX_W'(1);
        end
      end
    end
  end

  // element store: write on load, registered read of the next element to emit
  always_ff @(posedge clk) begin
    if (state == S_LOAD_MUL) mem[loaded_count[IDX_W-1:0]] <= cur.x;
    rd_data <= mem[emit_index];
  end

  always_ff @(posedge clk) begin
    if (take) cur <= head.item;
    if (state == S_LOAD_MUL) sqp <= (2*DATA_W)'(cur.x * cur.x);

    // shared restoring divider, one quotient bit per cycle
    if (state == S_MEAN_DIV || state == S_SQ_DIV || state == S_LIM_DIV) begin
      div_rem <= div_ge ? DEN_W'(div_shift - {1'b0, div_den}) : DEN_W'(div_shift);
      div_quo <= {div_quo[DIV_W-2:0], div_ge};
      div_cnt <= div_cnt - 7'd1;
    end
    if (take && !is_load && !phase && full) begin
      div_quo <= DIV_W'(sum_mag) + DIV_W'(loaded_count >> 1);
      div_den <= DEN_W'(loaded_count);
      div_rem <= '0;
      div_cnt <= 7'(DIV_W - 1);
    end
    if (state == S_MEAN_SET) begin
      m_mag       <= div_quo[DATA_W-1:0];
      vector_mean <= running_sum[SUM_W-1] ? -$signed(div_quo[DATA_W-1:0])
                                          : $signed(div_quo[DATA_W-1:0]);
      div_quo     <= DIV_W'(running_square_sum);
      div_rem     <= '0;
      div_cnt     <= 7'(DIV_W - 1);
    end
    if (state == S_MSQ) begin
      qn  <= div_quo[SQ_W-1:0];
      msq <= m_mag * m_mag;
    end
    if (state == S_VAR) begin
      if (v_small) begin
        reciprocal_std <= '1;
      end else begin
        div_quo <= DIV_W'(1) << 64;
        div_den <= v_comb;
        div_rem <= '0;
        div_cnt <= 7'(DIV_W - 1);
      end
    end
    if (state == S_LIM_SET) begin
      lim     <= div_quo[63:0];
      rsq_res <= '0;
      rsq_bit <= 5'd31;
    end
    if (state == S_RSQ_MUL) sqr <= 64'(rsq_cand) * 64'(rsq_cand);
    if (state == S_RSQ_CMP) begin
      if (sqr <= lim) rsq_res <= rsq_cand;
      if (rsq_bit == '0) reciprocal_std <= (sqr <= lim) ? rsq_cand : rsq_res;
      rsq_bit <= rsq_bit - 5'd1;
    end

    if (state == S_EMIT_MUL) prod <= 58'(d) * 58'($signed({1'b0, reciprocal_std}));
    if (state == S_EMIT_NORM) begin
      if (n_r > NORM_LIMIT) norm <= NORM_W'(NORM_LIMIT);
      else if (n_r < -NORM_LIMIT) norm <= NORM_W'(-NORM_LIMIT);
      else norm <= NORM_W'(n_r);
    end
    // split norm so each product stays narrow
    if (state == S_EMIT_SPLIT) begin
      ph <= 45'($signed(norm[NORM_W-1:20])) * 45'(cur.gamma);
      pl <= 45'($signed({1'b0, norm[19:0]})) * 45'(cur.gamma);
    end

    if (drop_now || early_now) begin
      normalized_value <= '0;
      element_index    <= '0;
      last_of_vector   <= 1'b0;
      status           <= drop_now ? STATUS_DROP : STATUS_EARLY;
    end
    if (state == S_EMIT_SUM) begin
      if (y_r > OUT_MAX) normalized_value <= DATA_W'(OUT_MAX);
      else if (y_r < OUT_MIN) normalized_value <= DATA_W'(OUT_MIN);
      else normalized_value <= DATA_W'(y_r);
      element_index  <= emit_index;
      last_of_vector <= last;
      status         <= STATUS_OK;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CNT_W'(MAX_LENGTH))
    else $error("loaded count above store depth");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    phase |-> (CNT_W'(emit_index) < loaded_count))
    else $error("emit index past loaded elements");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    !phase |-> (emit_index == '0))
    else $error("emit index moved while loading");

  a_emit_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_SUM) |=> result_valid)
    else $error("emit finished without result");

endmodule

### hw/rtl/layer_norm_engine.sv
// Top level of the layer normalization engine.
// Depends on lne_pkg, lne_front and lne_back.

// Normalizes one vector of signed Q8.16 elements. Send mode 0 requests to load
// elements, then one mode 1 request per element carrying gamma and beta; each
// returns (x - mean) * rstd * gamma + beta, saturated, with the last element
// flagged. A load runs the back end's multiply and accumulate states, an emit
// its read, multiply, normalize, split and sum states, set by the single-ported
// element store and multiply stages. The first emit of a vector also runs the
// statistics on a shared one-bit-per-cycle divider (mean, mean square, limit)
// and a 32-step root search; the limit division and search are skipped when
// variance plus epsilon is at most one. A two-entry queue takes requests while
// the back end works or a result waits. Write configuration only when idle.
module layer_norm_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [lne_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              mode,
  input  logic signed [lne_pkg::DATA_W-1:0] x_value,
  input  logic signed [lne_pkg::DATA_W-1:0] scale_value,
  input  logic signed [lne_pkg::DATA_W-1:0] shift_value,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [lne_pkg::DATA_W-1:0] normalized_value,
  output logic [lne_pkg::IDX_W-1:0]         element_index,
  output logic                              last_of_vector,
  output logic [1:0]                        status
);
  import lne_pkg::*;

  q_head_t head;
  logic    pop;

  lne_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .mode        (mode),
    .x_value     (x_value),
    .scale_value (scale_value),
    .shift_value (shift_value),
    .head        (head),
    .pop         (pop)
  );

  lne_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .head             (head),
    .pop              (pop),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .normalized_value (normalized_value),
    .element_index    (element_index),
    .last_of_vector   (last_of_vector),
    .status           (status)
  );

endmodule
